FILE: rtl/sapq_pkg.sv
// shared types and codes for the sorted array priority queue
package sapq_pkg;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CP_RD,
        ST_CP_WR,
        ST_INS_RD,
        ST_INS_CMP,
        ST_WRITE,
        ST_FRONT,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/sorted_array_priority_queue_unit.sv
// sorted array priority queue with one memory port pair and a compare sequencer
// a dequeue or a refused item goes straight to its result; an enqueue shifts every larger entry
// up one place, after first compacting the stored run to index 0 when it reaches the memory end
// one item at a time: the next item can be taken in the same cycle its result is presented
// reset: head and count clear at once; entries stay undefined until written
module sorted_array_priority_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          op,
    input  logic [DATA_WIDTH-1:0]         value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          accepted,
    output logic [DATA_WIDTH-1:0]         front_value,
    output logic                          empty_res,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import sapq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [DATA_WIDTH-1:0]  val_reg, val_next;
    logic                   ok_reg, ok_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   accepted_reg, accepted_next;
    logic [DATA_WIDTH-1:0]  front_reg, front_next;
    logic                   empty_reg, empty_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic [DATA_WIDTH-1:0]  mem [DEPTH];
    logic [DATA_WIDTH-1:0]  rdata_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0]  mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [SUM_W-1:0]       head_pos;
    logic [SUM_W-1:0]       head_cnt;
    logic                   req_take;
    logic                   rsp_take;

    assign head_pos = SUM_W'(head_reg) + SUM_W'(pos_reg);
    assign head_cnt = SUM_W'(head_reg) + SUM_W'(cnt_reg);
    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid_reg && !rsp_stall;

    assign req_stall   = (state_reg != ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign accepted    = accepted_reg;
    assign front_value = front_reg;
    assign empty_res   = empty_reg;
    assign count       = count_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            val_reg       <= '0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            front_reg     <= '0;
            empty_reg     <= 1'b1;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            val_reg       <= val_next;
            ok_reg        <= ok_next;
            rsp_valid_reg <= rsp_valid_next;
            accepted_reg  <= accepted_next;
            front_reg     <= front_next;
            empty_reg     <= empty_next;
            count_reg     <= count_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        val_next       = val_reg;
        ok_next        = ok_reg;
        rsp_valid_next = rsp_take ? 1'b0 : rsp_valid_reg;
        accepted_next  = accepted_reg;
        front_next     = front_reg;
        empty_next     = empty_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_waddr      = head_pos[ADDR_W-1:0];
        mem_wdata      = val_reg;
        mem_raddr      = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    val_next = value;
                    if (op == OP_DEQUEUE)
                    begin
                        if (cnt_reg == '0)
                        begin
                            ok_next = 1'b0;
                        end
                        else
                        begin
                            ok_next  = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                            if (cnt_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                            end
                            else
                            begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                        state_next = ST_FRONT;
                    end
                    else if (cnt_reg == CNT_W'(DEPTH))
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_FRONT;
                    end
                    else if (cnt_reg == '0)
                    begin
                        ok_next    = 1'b1;
                        head_next  = '0;
                        pos_next   = '0;
                        state_next = ST_WRITE;
                    end
                    else if (head_cnt >= SUM_W'(DEPTH))
                    begin
                        ok_next    = 1'b1;
                        k_next     = '0;
                        state_next = ST_CP_RD;
                    end
                    else
                    begin
                        ok_next    = 1'b1;
                        pos_next   = cnt_reg;
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_CP_RD:
            begin
                mem_raddr  = ADDR_W'(SUM_W'(head_reg) + SUM_W'(k_reg));
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg[ADDR_W-1:0];
                mem_wdata = rdata_reg;
                k_next    = k_reg + 1'b1;
                if (k_next == cnt_reg)
                begin
                    head_next  = '0;
                    pos_next   = cnt_reg;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = ST_CP_RD;
                end
            end
            ST_INS_RD:
            begin
                mem_raddr = ADDR_W'(head_pos - 1'b1);
                if (pos_reg == '0)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (rdata_reg > val_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = rdata_reg;
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_FRONT;
            end
            ST_FRONT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_take)
                begin
                    rsp_valid_next = 1'b1;
                    accepted_next  = ok_reg;
                    front_next     = (cnt_reg == '0) ? '0 : rdata_reg;
                    empty_next     = (cnt_reg == '0);
                    count_next     = cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sapq_checker.sv
// port-level checks for the sorted array priority queue, bound to the top level
module sapq_checker #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic                       op,
    input logic [DATA_WIDTH-1:0]      value,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input logic                       accepted,
    input logic [DATA_WIDTH-1:0]      front_value,
    input logic                       empty_res,
    input logic [$clog2(DEPTH+1)-1:0] count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("new item taken while previous item in progress");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (empty_res == (count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && empty_res |-> front_value == '0)
        else $error("front value not zero on empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count <= ($clog2(DEPTH+1))'(DEPTH))
        else $error("count above depth");

endmodule

bind sorted_array_priority_queue_unit sapq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_sapq_checker (.*);

FILE: tb/sorted_array_priority_queue_checker.sv
`timescale 1ns / 1ps
// checker that predicts the queue status for every item and compares each result
module sorted_array_priority_queue_checker #(
    parameter int DEPTH       = 16,
    parameter int DATA_WIDTH  = 16,
    parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  logic                   op,
    input  logic [DATA_WIDTH-1:0]  value,
    input  logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  logic                   accepted,
    input  logic [DATA_WIDTH-1:0]  front_value,
    input  logic                   empty_res,
    input  logic [COUNT_WIDTH-1:0] count,
    output int                     mismatches,
    output int                     outstanding
);
    import sapq_pkg::*;

    typedef struct packed {
        logic                   accepted;
        logic [DATA_WIDTH-1:0]  front_value;
        logic                   empty_res;
        logic [COUNT_WIDTH-1:0] count;
    } queue_status_t;

    logic [DATA_WIDTH-1:0] held_values [DEPTH];
    int                    held_count;
    queue_status_t         expected_status [$];

    // stored values kept sorted from index 0; equal values stay in arrival order
    function automatic queue_status_t apply_item(input logic item_op,
                                                 input logic [DATA_WIDTH-1:0] item_value);
        queue_status_t status;
        int            slot;
        status.accepted = 1'b0;
        if (item_op == OP_ENQUEUE)
        begin
            if (held_count < DEPTH)
            begin
                slot = held_count;
                while (slot > 0 && held_values[slot-1] > item_value)
                begin
                    held_values[slot] = held_values[slot-1];
                    slot--;
                end
                held_values[slot] = item_value;
                held_count++;
                status.accepted = 1'b1;
            end
        end
        else if (held_count > 0)
        begin
            for (int k = 1; k < held_count; k++)
                held_values[k-1] = held_values[k];
            held_count--;
            status.accepted = 1'b1;
        end
        status.front_value = (held_count > 0) ? held_values[0] : '0;
        status.empty_res   = (held_count == 0);
        status.count       = held_count[COUNT_WIDTH-1:0];
        return status;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_status_t want;
        if (!rst_n)
        begin
            held_count  = 0;
            mismatches  = 0;
            outstanding = 0;
            expected_status.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
                        mismatches++;
                    end
                    if (front_value !== want.front_value)
                    begin
                        $error("front_value: expected %0d, actual %0d",
                               want.front_value, front_value);
                        mismatches++;
                    end
                    if (empty_res !== want.empty_res)
                    begin
                        $error("empty_res: expected %0d, actual %0d", want.empty_res, empty_res);
                        mismatches++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, count);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_status.push_back(apply_item(op, value));
            outstanding = expected_status.size();
        end
    end

endmodule

FILE: tb/tb_sorted_array_priority_queue_unit.sv
`timescale 1ns / 1ps
// testbench top: drives queue items with idle and stall phases and gives the verdict
module tb_sorted_array_priority_queue_unit;
    import sapq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int DATA_WIDTH     = 16;
    localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
    localparam int PHASE_ITEMS    = 212;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   req_valid   = 1'b0;
    logic                   op          = OP_ENQUEUE;
    logic [DATA_WIDTH-1:0]  value       = '0;
    logic                   rsp_stall   = 1'b0;
    logic                   req_stall;
    logic                   rsp_valid;
    logic                   accepted;
    logic [DATA_WIDTH-1:0]  front_value;
    logic                   empty_res;
    logic [COUNT_WIDTH-1:0] count;

    int mismatches;
    int outstanding;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    sorted_array_priority_queue_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .accepted    (accepted),
        .front_value (front_value),
        .empty_res   (empty_res),
        .count       (count)
    );

    sorted_array_priority_queue_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) queue_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .accepted    (accepted),
        .front_value (front_value),
        .empty_res   (empty_res),
        .count       (count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input logic item_op, input logic [DATA_WIDTH-1:0] item_value);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        op        <= item_op;
        value     <= item_value;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // many duplicates from a narrow range, some extremes, the rest anywhere
    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int mode;
        mode = $urandom_range(99);
        if (mode < 40)
            return DATA_WIDTH'($urandom_range(7));
        else if (mode < 50)
            return ($urandom_range(1) != 0) ? '1 : '0;
        else
            return DATA_WIDTH'($urandom);
    endfunction

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int enqueue_pct;
        int burst_left;
        enqueue_pct = 50;
        burst_left  = 0;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                case ($urandom_range(2))
                    0:       enqueue_pct = 80;
                    1:       enqueue_pct = 20;
                    default: enqueue_pct = 50;
                endcase
                burst_left = $urandom_range(40, 15);
            end
            burst_left--;
            if ($urandom_range(99) < enqueue_pct)
                send_item(OP_ENQUEUE, pick_value());
            else
                send_item(OP_DEQUEUE, DATA_WIDTH'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty refusal, emptying, extremes, ties, full refusal, wrap with compaction
        send_item(OP_DEQUEUE, '1);
        send_item(OP_ENQUEUE, '1);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_ENQUEUE, '1);
        send_item(OP_ENQUEUE, '0);
        send_item(OP_ENQUEUE, 16'h5555);
        send_item(OP_ENQUEUE, 16'hAAAA);
        send_item(OP_ENQUEUE, 16'h5555);
        for (int n = 0; n < DEPTH - 5; n++)
            send_item(OP_ENQUEUE, DATA_WIDTH'($urandom));
        send_item(OP_ENQUEUE, 16'h1234);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_ENQUEUE, 16'h0007);
        send_item(OP_ENQUEUE, '1);
        send_item(OP_ENQUEUE, '0);

        run_random_phase(0, 0);
        run_random_phase(46, 0);
        run_random_phase(0, 46);
        run_random_phase(29, 29);

        @(negedge clk);
        req_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
